// ===== rtl/core/packed_3bit_framebuffer_unit_assert.svh =====
// Assertion macros for the packed 3-bit frame buffer unit.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef PACKED_3BIT_FRAMEBUFFER_UNIT_ASSERT_SVH
`define PACKED_3BIT_FRAMEBUFFER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbf assertion failed");

`endif

// ===== rtl/core/pbf_pkg.sv =====
// Shared types, constants and the RGB565 palette of the packed 3-bit frame buffer.
// No dependencies.
package pbf_pkg;

  localparam int FrameWidthDef  = 240;
  localparam int FrameHeightDef = 240;
  localparam int PixPerWord     = 10;
  localparam int PixLast        = 9;
  localparam int FieldW         = 3;
  localparam int WordW          = PixPerWord * FieldW;
  localparam int RgbW           = 16;
  localparam int OpW            = 2;
  localparam int FieldIdxW      = 4;
  localparam int Div10Mul       = 205;
  localparam int Div10Shift     = 11;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_SCAN  = 2'd2
  } pbf_op_e;

  typedef struct packed {
    logic init_busy;
  } pbf_status_t;

  function automatic logic [RgbW-1:0] pbf_palette(input logic [FieldW-1:0] idx);
    logic [RgbW-1:0] rgb;
    unique case (idx)
      3'd0: rgb = 16'h0000;
      3'd1: rgb = 16'h001F;
      3'd2: rgb = 16'h07E0;
      3'd3: rgb = 16'h07FF;
      3'd4: rgb = 16'hF800;
      3'd5: rgb = 16'hF81F;
      3'd6: rgb = 16'hFFE0;
      default: rgb = 16'hFFFF;
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/core/pbf_if.sv =====
// Valid/ready channel interfaces for the command input and the pixel output.
// No dependencies.
interface pbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [15:0] color;
  logic [12:0] word_index;

  modport source (output valid, command, x, y, color, word_index, input ready);
  modport sink (input valid, command, x, y, color, word_index, output ready);
endinterface

interface pbf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_rgb565;
  logic        last;

  modport source (output valid, pixel_rgb565, last, input ready);
  modport sink (input valid, pixel_rgb565, last, output ready);
endinterface

// ===== rtl/core/packed_3bit_framebuffer_unit.sv =====
// Top level of the packed 3-bit frame buffer: front end, command queue and back end.
// Depends on pbf_pkg, pbf_if, pbf_front, pbf_queue, pbf_back and the assertion header.
//
//   Channel  Direction  Payload                              One transaction
//   in_i     sink       command, x, y, color, word_index     one command
//   out_o    source     pixel_rgb565, last                   one palette pixel
//
// After reset every word of the frame store is swept to black, and no command is
// taken until the sweep ends. A draw is one read and one write of the single store
// port pair, in ST_DRAW_RD and ST_DRAW_WR. A scan reads one word in ST_SCAN_RD and
// ST_SCAN_LD, then emits its ten pixels, one pixel per cycle while out_o is ready.
// A clear sweeps the store to black again in ST_CLEAR. The two-entry queue lets the front end take
// commands while the back end works or while out_o stalls.
module packed_3bit_framebuffer_unit #(
  parameter int FRAME_WIDTH  = pbf_pkg::FrameWidthDef,
  parameter int FRAME_HEIGHT = pbf_pkg::FrameHeightDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbf_in_if.sink    in_i,
  pbf_out_if.source out_o
);
  import pbf_pkg::*;

`include "packed_3bit_framebuffer_unit_assert.svh"

  localparam int WordsPerRow = (FRAME_WIDTH + PixPerWord - 1) / PixPerWord;
  localparam int StoreDepth  = WordsPerRow * FRAME_HEIGHT;
  localparam int AddrW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int EntryW      = OpW + FieldIdxW + FieldW + AddrW;

  pbf_status_t       status;
  logic              q_push;
  logic [EntryW-1:0] q_push_data;
  logic              q_full;
  logic              q_pop;
  logic [EntryW-1:0] q_pop_data;
  logic              q_empty;

  pbf_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .ADDR_W      (AddrW),
    .ENTRY_W     (EntryW)
  ) u_front (
    .in_i       (in_i),
    .status_i   (status),
    .full_i     (q_full),
    .push_o     (q_push),
    .push_data_o(q_push_data)
  );

  pbf_queue #(
    .ENTRY_W(EntryW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_data_o (q_pop_data),
    .empty_o    (q_empty)
  );

  pbf_back #(
    .STORE_DEPTH(StoreDepth),
    .ADDR_W     (AddrW),
    .ENTRY_W    (EntryW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (q_pop_data),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .status_o(status),
    .out_o   (out_o)
  );

  `PBF_ASSERT_NOW(a_no_accept_during_init, status.init_busy, !in_i.ready)
  `PBF_ASSERT_NOW(a_no_push_when_full, q_full, !q_push)
  `PBF_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_empty)
  `PBF_ASSERT_NEXT(a_init_stays_done, !status.init_busy, !status.init_busy)

endmodule

// ===== rtl/core/pbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbf_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 5760
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pbf_queue.sv =====
// Two-entry queue that carries classified commands from the front to the back.
// No dependencies.
module pbf_queue #(
  parameter int ENTRY_W = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [ENTRY_W-1:0] push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic [ENTRY_W-1:0] pop_data_o,
  output logic               empty_o
);

  logic [ENTRY_W-1:0] entry_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = count_q[1];
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];

endmodule

// ===== rtl/core/pbf_front.sv =====
// Front end: accepts commands, drops those with no effect, and computes word addresses.
// Depends on pbf_pkg and pbf_in_if.
module pbf_front #(
  parameter int FRAME_WIDTH  = pbf_pkg::FrameWidthDef,
  parameter int FRAME_HEIGHT = pbf_pkg::FrameHeightDef,
  parameter int ADDR_W       = 13,
  parameter int ENTRY_W      = 22
) (
  pbf_in_if.sink                 in_i,
  input  pbf_pkg::pbf_status_t   status_i,
  input  logic                   full_i,
  output logic                   push_o,
  output logic [ENTRY_W-1:0]     push_data_o
);
  import pbf_pkg::*;

  localparam int WordsPerRow = (FRAME_WIDTH + PixPerWord - 1) / PixPerWord;
  localparam int StoreDepth  = WordsPerRow * FRAME_HEIGHT;

  logic [15:0]          div_prod;
  logic [4:0]           x_word;
  logic [FieldIdxW-1:0] x_field;
  logic [ADDR_W-1:0]    draw_addr;
  logic                 draw_ok;
  logic                 scan_ok;
  logic                 keep;
  logic [ADDR_W-1:0]    addr;
  logic [FieldIdxW-1:0] field;
  pbf_op_e              op;

  always_comb begin
    div_prod  = 16'(in_i.x) * 16'(Div10Mul);
    x_word    = div_prod[15:Div10Shift];
    x_field   = FieldIdxW'(in_i.x - 8'(x_word) * 8'(PixPerWord));
    draw_addr = ADDR_W'(32'(in_i.y) * 32'(WordsPerRow) + 32'(x_word));
    draw_ok   = (32'(in_i.x) < 32'(FRAME_WIDTH)) && (32'(in_i.y) < 32'(FRAME_HEIGHT));
    scan_ok   = 32'(in_i.word_index) < 32'(StoreDepth);
    op        = pbf_op_e'(in_i.command);
    keep      = 1'b0;
    addr      = '0;
    field     = '0;
    unique case (in_i.command)
      OP_CLEAR: keep = 1'b1;
      OP_DRAW: begin
        keep  = draw_ok;
        addr  = draw_addr;
        field = x_field;
      end
      OP_SCAN: begin
        keep = scan_ok;
        addr = ADDR_W'(in_i.word_index);
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_i.ready  = !full_i && !status_i.init_busy;
  assign push_o      = in_i.valid && in_i.ready && keep;
  assign push_data_o = {op, field, in_i.color[FieldW-1:0], addr};

endmodule

// ===== rtl/core/pbf_back.sv =====
// Back end: runs clear sweeps, pixel read-modify-writes and word scans on the frame store.
// Depends on pbf_pkg, pbf_out_if and pbf_ram.
module pbf_back #(
  parameter int STORE_DEPTH = 5760,
  parameter int ADDR_W      = 13,
  parameter int ENTRY_W     = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ENTRY_W-1:0]   entry_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output pbf_pkg::pbf_status_t status_o,
  pbf_out_if.source            out_o
);
  import pbf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_CLEAR   = 6'b000010,
    ST_DRAW_RD = 6'b000100,
    ST_DRAW_WR = 6'b001000,
    ST_SCAN_RD = 6'b010000,
    ST_SCAN_LD = 6'b100000
  } pbf_state_e;

  typedef enum logic [1:0] {
    PH_WAIT = 2'b01,
    PH_EMIT = 2'b10
  } pbf_phase_e;

  pbf_state_e           state_q, state_d;
  pbf_phase_e           phase_q, phase_d;
  logic                 init_q, init_d;
  logic [ADDR_W-1:0]    clr_ptr_q, clr_ptr_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [FieldIdxW-1:0] field_q, field_d;
  logic [FieldW-1:0]    color_q, color_d;
  logic [WordW-1:0]     word_q, word_d;
  logic [FieldIdxW-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic [RgbW-1:0]      out_pix_q, out_pix_d;
  logic                 out_last_q, out_last_d;

  pbf_op_e              entry_op;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WordW-1:0]     ram_wdata;
  logic [WordW-1:0]     ram_rdata;
  logic [4:0]           shift;
  logic [WordW-1:0]     field_mask;
  logic                 out_free;

  pbf_ram #(
    .WIDTH(WordW),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  assign entry_op = pbf_op_e'(entry_i[ENTRY_W-1 -: OpW]);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    init_d      = init_q;
    clr_ptr_d   = clr_ptr_q;
    addr_d      = addr_q;
    field_d     = field_q;
    color_d     = color_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_ptr_q;
    ram_wdata   = '0;
    shift       = 5'({1'b0, field_q, 1'b0} + {2'b00, field_q});
    field_mask  = WordW'({FieldW{1'b1}}) << shift;

    unique case (state_q)
      ST_IDLE: begin
        if (phase_q == PH_EMIT) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_pix_d   = pbf_palette(word_q[FieldW-1:0]);
            out_last_d  = (cnt_q == FieldIdxW'(PixLast));
            word_d      = word_q >> FieldW;
            cnt_d       = cnt_q + 1'b1;
            if (cnt_q == FieldIdxW'(PixLast)) begin
              phase_d = PH_WAIT;
            end
          end
        end else if (!empty_i) begin
          pop_o   = 1'b1;
          addr_d  = entry_i[ADDR_W-1:0];
          color_d = entry_i[ADDR_W +: FieldW];
          field_d = entry_i[ADDR_W + FieldW +: FieldIdxW];
          unique case (entry_op)
            OP_CLEAR: state_d = ST_CLEAR;
            OP_DRAW:  state_d = ST_DRAW_RD;
            OP_SCAN:  state_d = ST_SCAN_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_ptr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          clr_ptr_d = '0;
          init_d    = 1'b0;
          state_d   = ST_IDLE;
        end else begin
          clr_ptr_d = clr_ptr_q + 1'b1;
        end
      end
      ST_DRAW_RD: state_d = ST_DRAW_WR;
      ST_DRAW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = (ram_rdata & ~field_mask) | (WordW'(color_q) << shift);
        state_d   = ST_IDLE;
      end
      ST_SCAN_RD: state_d = ST_SCAN_LD;
      ST_SCAN_LD: begin
        word_d  = ram_rdata;
        cnt_d   = '0;
        phase_d = PH_EMIT;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_WAIT;
      init_q      <= 1'b1;
      clr_ptr_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      init_q      <= init_d;
      clr_ptr_q   <= clr_ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    field_q    <= field_d;
    color_q    <= color_d;
    word_q     <= word_d;
    out_pix_q  <= out_pix_d;
    out_last_q <= out_last_d;
  end

  assign status_o.init_busy = init_q;
  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_rgb565 = out_pix_q;
  assign out_o.last         = out_last_q;

endmodule

// ===== sim/pbf_frame_model_pkg.sv =====
// Scoreboard for the packed 3-bit frame buffer: a copy of the frame store and the queue of expected pixels.
// Depends on pbf_pkg for the widths, the default frame size and the command codes.
package pbf_frame_model_pkg;

  import pbf_pkg::*;

  localparam int WordsPerRow = (FrameWidthDef + PixPerWord - 1) / PixPerWord;
  localparam int StoreDepth  = WordsPerRow * FrameHeightDef;
  localparam int MaxReported = 10;

  localparam logic [8*RgbW-1:0] Rgb565Lut = {
    16'hFFFF, 16'hFFE0, 16'hF81F, 16'hF800,
    16'h07FF, 16'h07E0, 16'h001F, 16'h0000
  };

  typedef struct packed {
    logic [RgbW-1:0] rgb;
    logic            last;
  } pixel_t;

  class pbf_frame_model;
    logic [WordW-1:0] words [StoreDepth];
    pixel_t           expected_pixels [$];
    int unsigned      failures;
    int unsigned      pixels_seen;

    function new();
      wipe();
      failures    = 0;
      pixels_seen = 0;
    endfunction

    function void wipe();
      foreach (words[i]) words[i] = '0;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function void mismatch(input string what);
      failures++;
      if (failures <= MaxReported) begin
        $display("pixel %0d: %s", pixels_seen, what);
      end
    endfunction

    function void note_command(input logic [OpW-1:0] command, input logic [7:0] x,
                               input logic [7:0] y, input logic [RgbW-1:0] color,
                               input logic [12:0] word_index);
      int     addr;
      int     shift;
      pixel_t px;
      case (command)
        OP_CLEAR: begin
          wipe();
        end
        OP_DRAW: begin
          if (int'(x) < FrameWidthDef && int'(y) < FrameHeightDef) begin
            addr  = int'(y) * WordsPerRow + int'(x) / PixPerWord;
            shift = (int'(x) % PixPerWord) * FieldW;
            words[addr][shift +: FieldW] = color[FieldW-1:0];
          end
        end
        OP_SCAN: begin
          if (int'(word_index) < StoreDepth) begin
            for (int k = 0; k < PixPerWord; k++) begin
              px.rgb  = Rgb565Lut[int'(words[word_index][k*FieldW +: FieldW]) * RgbW +: RgbW];
              px.last = (k == PixLast);
              expected_pixels.push_back(px);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_pixel(input logic [RgbW-1:0] rgb, input logic last);
      pixel_t want;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        mismatch($sformatf("unexpected transaction, rgb565 %h last %b", rgb, last));
        return;
      end
      want = expected_pixels.pop_front();
      if (want.rgb !== rgb) begin
        mismatch($sformatf("rgb565 expected %h, got %h", want.rgb, rgb));
      end
      if (want.last !== last) begin
        mismatch($sformatf("last expected %b, got %b", want.last, last));
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_packed_3bit_framebuffer_unit.sv =====
// Top of the frame buffer testbench: clock, reset, command and pixel drivers, watchdog.
// Depends on pbf_pkg, pbf_if, pbf_frame_model_pkg and the packed_3bit_framebuffer_unit RTL.
module tb_packed_3bit_framebuffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pbf_pkg::*;
  import pbf_frame_model_pkg::*;

  localparam int              RandomItems   = 100;
  localparam int              WatchdogLimit = 25000;
  localparam int              TailCycles    = 50;
  localparam logic [OpW-1:0]  OpUnused      = 2'd3;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  int unsigned    cmd_burst = 0;
  int unsigned    pix_burst = 0;
  int unsigned    idle_cycles = 0;
  pbf_frame_model frame_model;

  pbf_in_if  cmd_if ();
  pbf_out_if pix_if ();

  packed_3bit_framebuffer_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (pix_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned next_gap(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(5, 20);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] hot_row();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd120;
      4: return 8'd238;
      default: return 8'd239;
    endcase
  endfunction

  task automatic send_command(input logic [OpW-1:0] op, input logic [7:0] x,
                              input logic [7:0] y, input logic [RgbW-1:0] color,
                              input logic [12:0] word_index);
    int unsigned gap;
    gap = next_gap(cmd_burst);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= op;
    cmd_if.x          <= x;
    cmd_if.y          <= y;
    cmd_if.color      <= color;
    cmd_if.word_index <= word_index;
    @(posedge clk_i);
    while (cmd_if.ready !== 1'b1) @(posedge clk_i);
    frame_model.note_command(op, x, y, color, word_index);
  endtask

  initial begin
    int unsigned     done_items;
    int unsigned     pick;
    logic [7:0]      x;
    logic [7:0]      y;
    logic [12:0]     word;
    frame_model = new();
    rst_ni            <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= OP_CLEAR;
    cmd_if.x          <= '0;
    cmd_if.y          <= '0;
    cmd_if.color      <= '0;
    cmd_if.word_index <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(OP_SCAN, 8'd0, 8'd0, 16'h0000, 13'd0);
    for (int k = 0; k < PixPerWord; k++) begin
      send_command(OP_DRAW, 8'(k), 8'd0, {13'($urandom), 3'(k % 8)}, 13'd0);
    end
    send_command(OP_SCAN, 8'd0, 8'd0, 16'h0000, 13'd0);
    send_command(OP_DRAW, 8'd239, 8'd239, 16'hFFFF, 13'd0);
    send_command(OP_SCAN, 8'd0, 8'd0, 16'h0000, 13'(StoreDepth - 1));
    send_command(OP_DRAW, 8'd240, 8'd0, 16'h0007, 13'd0);
    send_command(OP_DRAW, 8'd0, 8'd240, 16'h0005, 13'd0);
    send_command(OP_DRAW, 8'hFF, 8'hFF, 16'hFFFF, 13'h1FFF);
    send_command(OpUnused, 8'd0, 8'd0, 16'h0003, 13'd0);
    send_command(OP_SCAN, 8'd0, 8'd0, 16'h0000, 13'(StoreDepth));
    send_command(OP_SCAN, 8'd0, 8'd0, 16'h0000, 13'h1FFF);
    send_command(OP_CLEAR, 8'd0, 8'd0, 16'h0000, 13'd0);
    send_command(OP_SCAN, 8'd0, 8'd0, 16'h0000, 13'd0);
    send_command(OP_SCAN, 8'd0, 8'd0, 16'h0000, 13'(StoreDepth - 1));

    // Most traffic lands on a few rows so that scans read back pixels that were drawn.
    done_items = 0;
    while (done_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_command(OP_DRAW, 8'($urandom_range(0, FrameWidthDef - 1)), hot_row(),
                     16'($urandom), 13'($urandom));
        done_items++;
      end else if (pick < 80) begin
        word = 13'(int'(hot_row()) * WordsPerRow + $urandom_range(0, WordsPerRow - 1));
        send_command(OP_SCAN, 8'($urandom), 8'($urandom), 16'($urandom), word);
        done_items++;
      end else if (pick < 86) begin
        send_command(OP_DRAW, 8'($urandom_range(0, FrameWidthDef - 1)),
                     8'($urandom_range(0, FrameHeightDef - 1)), 16'($urandom), 13'($urandom));
        done_items++;
      end else if (pick < 89) begin
        send_command(OP_SCAN, 8'($urandom), 8'($urandom), 16'($urandom),
                     13'($urandom_range(0, StoreDepth - 1)));
        done_items++;
      end else if (pick < 93) begin
        x = 8'($urandom);
        y = 8'($urandom);
        if ($urandom_range(0, 1) == 0) begin
          x = 8'($urandom_range(FrameWidthDef, 255));
        end else begin
          y = 8'($urandom_range(FrameHeightDef, 255));
        end
        send_command(OP_DRAW, x, y, 16'($urandom), 13'($urandom));
        done_items++;
      end else if (pick < 96) begin
        send_command(OP_SCAN, 8'($urandom), 8'($urandom), 16'($urandom),
                     13'($urandom_range(StoreDepth, 8191)));
        done_items++;
      end else if (pick < 98) begin
        send_command(OpUnused, 8'($urandom), 8'($urandom), 16'($urandom), 13'($urandom));
        done_items++;
      end else begin
        send_command(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), 13'($urandom));
        done_items++;
      end
    end
    cmd_if.valid <= 1'b0;

    while (frame_model.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (frame_model.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    pix_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = next_gap(pix_burst);
      if (gap != 0) begin
        pix_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pix_if.ready <= 1'b1;
      @(posedge clk_i);
      while (pix_if.valid !== 1'b1) @(posedge clk_i);
      frame_model.check_pixel(pix_if.pixel_rgb565, pix_if.last);
    end
  end

  // A clear or the sweep after reset holds off transactions while the frame store is swept.
  always @(posedge clk_i) begin
    if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
        (pix_if.valid === 1'b1 && pix_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pbf_pkg.sv
rtl/core/pbf_if.sv
rtl/core/pbf_ram.sv
rtl/core/pbf_queue.sv
rtl/core/pbf_front.sv
rtl/core/pbf_back.sv
rtl/core/packed_3bit_framebuffer_unit.sv
sim/pbf_frame_model_pkg.sv
sim/tb_packed_3bit_framebuffer_unit.sv
